/* rtl/rmpi_pkg.sv */
// Shared types and codes for the recursive mutex lock unit.
`default_nettype none

package rmpi_pkg;

  // Task identifier width
  localparam int TASK_ID_W = 5;

  // Request commands
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // Result status codes
  localparam int STATUS_W = 4;
  localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_RECURSIVE  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_DEPTH_DOWN = 4'd5;
  localparam logic [STATUS_W-1:0] ST_HANDED     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FREED      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_BAD_UNLOCK = 4'd8;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 4'd9;

  // Waiter queue control from the lock logic
  typedef struct packed {
    logic push;
    logic pop;
  } wq_ctl_t;

  // Waiter queue status to the lock logic
  typedef struct packed {
    logic empty;
    logic full;
  } wq_stat_t;

endpackage

`default_nettype wire

/* rtl/recursive_mutex_priority_inherit_top.sv */
// Top level of the recursive mutex lock unit with priority inheritance.
// A request waits in the request register; when it fires, its result is registered.
// One request per cycle unless stalled; owner and waiter state update in one pass.
// The request register and result register keep flowing while the output side accepts.
// Reset (rst_n low, synchronous): mutex free, no owner, waiter queue empty.
// Waiter queue contents are not cleared; entries are read only after being written.
`default_nettype none

module recursive_mutex_priority_inherit_top #(
  parameter int MAX_TASKS  = 32,
  parameter int PRIO_BITS  = 8,
  parameter int DEPTH_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_command,
  input  wire  [rmpi_pkg::TASK_ID_W-1:0]   in_task_id,
  input  wire                              in_task_present,
  input  wire  [PRIO_BITS-1:0]             in_task_priority,
  input  wire  [PRIO_BITS-1:0]             in_task_base_priority,
  input  wire                              in_no_wait,
  input  wire                              in_scheduler_running,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [rmpi_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_success,
  output logic                             out_wake_valid,
  output logic [rmpi_pkg::TASK_ID_W-1:0]   out_wake_task,
  output logic                             out_prio_update_valid,
  output logic [rmpi_pkg::TASK_ID_W-1:0]   out_prio_update_task,
  output logic [PRIO_BITS-1:0]             out_prio_update_value
);

  localparam int IDW = rmpi_pkg::TASK_ID_W;

  // Request register
  logic                 req_valid_r;
  logic                 req_cmd_r;
  logic [IDW-1:0]       req_id_r;
  logic                 req_present_r;
  logic [PRIO_BITS-1:0] req_prio_r;
  logic [PRIO_BITS-1:0] req_base_r;
  logic                 req_no_wait_r;
  logic                 req_running_r;

  // Mutex state
  logic                  locked_r, locked_nxt;
  logic                  own_valid_r, own_valid_nxt;
  logic [IDW-1:0]        own_task_r, own_task_nxt;
  logic [PRIO_BITS-1:0]  own_eff_r, own_eff_nxt;
  logic [PRIO_BITS-1:0]  own_base_r, own_base_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;

  // Result register
  logic                         res_valid_r;
  logic [rmpi_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                         res_success_r, res_success_nxt;
  logic                         res_wake_r, res_wake_nxt;
  logic [IDW-1:0]               res_wake_task_r, res_wake_task_nxt;
  logic                         res_pu_valid_r, res_pu_valid_nxt;
  logic [IDW-1:0]               res_pu_task_r, res_pu_task_nxt;
  logic [PRIO_BITS-1:0]         res_pu_value_r, res_pu_value_nxt;

  logic in_xfer;
  logic res_ready;
  logic req_fire;

  rmpi_pkg::wq_ctl_t    wq_ctl;
  rmpi_pkg::wq_ctl_t    wq_req;
  rmpi_pkg::wq_stat_t   wq_stat;
  logic [IDW-1:0]       head_id;
  logic [PRIO_BITS-1:0] head_prio;
  logic [PRIO_BITS-1:0] head_base;

  logic is_owner;

  // Handshake: the request moves on when the result register is free or drains
  assign res_ready = !res_valid_r || !out_stall;
  assign req_fire  = req_valid_r && res_ready;
  assign in_stall  = req_valid_r && !res_ready;
  assign in_xfer   = in_valid && !in_stall;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_xfer) begin
      req_valid_r <= 1'b1;
    end else if (req_fire) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_cmd_r     <= in_command;
      req_id_r      <= in_task_id;
      req_present_r <= in_task_present;
      req_prio_r    <= in_task_priority;
      req_base_r    <= in_task_base_priority;
      req_no_wait_r <= in_no_wait;
      req_running_r <= in_scheduler_running;
    end
  end

  rmpi_waitq #(
    .MAX_TASKS (MAX_TASKS),
    .PRIO_BITS (PRIO_BITS)
  ) u_waitq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wq_ctl),
    .push_id   (req_id_r),
    .push_prio (req_prio_r),
    .push_base (req_base_r),
    .head_id   (head_id),
    .head_prio (head_prio),
    .head_base (head_base),
    .stat      (wq_stat)
  );

  assign is_owner = own_valid_r && (own_task_r == req_id_r);

  // Decide the request against the current owner and queue
  always_comb begin
    locked_nxt        = locked_r;
    own_valid_nxt     = own_valid_r;
    own_task_nxt      = own_task_r;
    own_eff_nxt       = own_eff_r;
    own_base_nxt      = own_base_r;
    depth_nxt         = depth_r;
    wq_req            = '0;
    res_status_nxt    = rmpi_pkg::ST_IGNORED;
    res_success_nxt   = 1'b0;
    res_wake_nxt      = 1'b0;
    res_wake_task_nxt = '0;
    res_pu_valid_nxt  = 1'b0;
    res_pu_task_nxt   = '0;
    res_pu_value_nxt  = '0;

    if (!req_running_r) begin
      res_status_nxt  = rmpi_pkg::ST_IGNORED;
      res_success_nxt = 1'b1;
    end else if (req_cmd_r == rmpi_pkg::CMD_LOCK) begin
      if (!locked_r) begin
        locked_nxt      = 1'b1;
        depth_nxt       = DEPTH_BITS'(1);
        own_valid_nxt   = req_present_r;
        own_task_nxt    = req_present_r ? req_id_r : '0;
        own_eff_nxt     = req_present_r ? req_prio_r : '0;
        own_base_nxt    = req_present_r ? req_base_r : '0;
        res_success_nxt = 1'b1;
        res_status_nxt  = rmpi_pkg::ST_ACQUIRED;
      end else if (req_present_r && is_owner) begin
        if (&depth_r) begin
          res_status_nxt = rmpi_pkg::ST_OVERFLOW;
        end else begin
          depth_nxt       = depth_r + DEPTH_BITS'(1);
          res_success_nxt = 1'b1;
          res_status_nxt  = rmpi_pkg::ST_RECURSIVE;
        end
      end else if (req_no_wait_r) begin
        res_status_nxt = rmpi_pkg::ST_REFUSED;
      end else if (!req_present_r) begin
        res_success_nxt = 1'b1;
        res_status_nxt  = rmpi_pkg::ST_IGNORED;
      end else if (wq_stat.full) begin
        res_status_nxt = rmpi_pkg::ST_OVERFLOW;
      end else begin
        // Raise the owner to a higher-priority waiter
        if (own_valid_r && (req_prio_r > own_eff_r)) begin
          own_eff_nxt      = req_prio_r;
          res_pu_valid_nxt = 1'b1;
          res_pu_task_nxt  = own_task_r;
          res_pu_value_nxt = req_prio_r;
        end
        wq_req.push     = 1'b1;
        res_success_nxt = 1'b1;
        res_status_nxt  = rmpi_pkg::ST_QUEUED;
      end
    end else begin
      if (!locked_r || (req_present_r && !is_owner)) begin
        res_status_nxt = rmpi_pkg::ST_BAD_UNLOCK;
      end else if (depth_r > DEPTH_BITS'(1)) begin
        depth_nxt       = depth_r - DEPTH_BITS'(1);
        res_success_nxt = 1'b1;
        res_status_nxt  = rmpi_pkg::ST_DEPTH_DOWN;
      end else begin
        res_success_nxt = 1'b1;
        // Restore the releasing owner's base priority
        if (own_valid_r && (own_eff_r != own_base_r)) begin
          res_pu_valid_nxt = 1'b1;
          res_pu_task_nxt  = own_task_r;
          res_pu_value_nxt = own_base_r;
        end
        if (!wq_stat.empty) begin
          // Hand ownership to the oldest waiter
          wq_req.pop        = 1'b1;
          own_valid_nxt     = 1'b1;
          own_task_nxt      = head_id;
          own_eff_nxt       = head_prio;
          own_base_nxt      = head_base;
          depth_nxt         = DEPTH_BITS'(1);
          res_wake_nxt      = 1'b1;
          res_wake_task_nxt = head_id;
          res_status_nxt    = rmpi_pkg::ST_HANDED;
        end else begin
          locked_nxt     = 1'b0;
          own_valid_nxt  = 1'b0;
          own_task_nxt   = '0;
          own_eff_nxt    = '0;
          own_base_nxt   = '0;
          depth_nxt      = '0;
          res_status_nxt = rmpi_pkg::ST_FREED;
        end
      end
    end
  end

  // Touch the queue only when the request is taken
  assign wq_ctl.push = wq_req.push && req_fire;
  assign wq_ctl.pop  = wq_req.pop && req_fire;

  // Update mutex state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r    <= 1'b0;
      own_valid_r <= 1'b0;
      own_task_r  <= '0;
      own_eff_r   <= '0;
      own_base_r  <= '0;
      depth_r     <= '0;
    end else if (req_fire) begin
      locked_r    <= locked_nxt;
      own_valid_r <= own_valid_nxt;
      own_task_r  <= own_task_nxt;
      own_eff_r   <= own_eff_nxt;
      own_base_r  <= own_base_nxt;
      depth_r     <= depth_nxt;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_ready) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_status_r    <= res_status_nxt;
      res_success_r   <= res_success_nxt;
      res_wake_r      <= res_wake_nxt;
      res_wake_task_r <= res_wake_task_nxt;
      res_pu_valid_r  <= res_pu_valid_nxt;
      res_pu_task_r   <= res_pu_task_nxt;
      res_pu_value_r  <= res_pu_value_nxt;
    end
  end

  assign out_valid             = res_valid_r;
  assign out_status            = res_status_r;
  assign out_success           = res_success_r;
  assign out_wake_valid        = res_wake_r;
  assign out_wake_task         = res_wake_task_r;
  assign out_prio_update_valid = res_pu_valid_r;
  assign out_prio_update_task  = res_pu_task_r;
  assign out_prio_update_value = res_pu_value_r;

endmodule

`default_nettype wire

/* rtl/rmpi_waitq.sv */
// FIFO of tasks waiting on the mutex, with head entry read out.
`default_nettype none

module rmpi_waitq #(
  parameter int MAX_TASKS = 32,
  parameter int PRIO_BITS = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  rmpi_pkg::wq_ctl_t            ctl,
  input  wire  [rmpi_pkg::TASK_ID_W-1:0]     push_id,
  input  wire  [PRIO_BITS-1:0]               push_prio,
  input  wire  [PRIO_BITS-1:0]               push_base,
  output logic [rmpi_pkg::TASK_ID_W-1:0]     head_id,
  output logic [PRIO_BITS-1:0]               head_prio,
  output logic [PRIO_BITS-1:0]               head_base,
  output rmpi_pkg::wq_stat_t                 stat
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  logic [rmpi_pkg::TASK_ID_W-1:0] id_mem   [MAX_TASKS];
  logic [PRIO_BITS-1:0]           prio_mem [MAX_TASKS];
  logic [PRIO_BITS-1:0]           base_mem [MAX_TASKS];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [rmpi_pkg::TASK_ID_W-1:0] head_id_r;
  logic [PRIO_BITS-1:0]           head_prio_r;
  logic [PRIO_BITS-1:0]           head_base_r;

  // Advance pointers with wrap at the last slot
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
    if (ctl.push) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
    end
    if (ctl.pop) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write the new waiter at the tail; register the entry at the next head,
  // taking the new waiter directly when it lands on that slot
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      id_mem[tail_r]   <= push_id;
      prio_mem[tail_r] <= push_prio;
      base_mem[tail_r] <= push_base;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      head_id_r   <= push_id;
      head_prio_r <= push_prio;
      head_base_r <= push_base;
    end else begin
      head_id_r   <= id_mem[head_nxt];
      head_prio_r <= prio_mem[head_nxt];
      head_base_r <= base_mem[head_nxt];
    end
  end

  // Present the oldest waiter
  assign head_id    = head_id_r;
  assign head_prio  = head_prio_r;
  assign head_base  = head_base_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(MAX_TASKS));

endmodule

`default_nettype wire

/* rtl/rmpi_checker.sv */
// Port-level checks for the recursive mutex lock unit, bound to the top level.
`default_nettype none

module rmpi_checker #(
  parameter int PRIO_BITS = 8
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [rmpi_pkg::STATUS_W-1:0]     out_status,
  input wire                              out_success,
  input wire                              out_wake_valid,
  input wire [rmpi_pkg::TASK_ID_W-1:0]    out_wake_task,
  input wire                              out_prio_update_valid,
  input wire [rmpi_pkg::TASK_ID_W-1:0]    out_prio_update_task,
  input wire [PRIO_BITS-1:0]              out_prio_update_value
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
      $stable(out_success) && $stable(out_wake_task) &&
      $stable(out_prio_update_value)))
    else $error("result changed while stalled");

  // Input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

  // A wakeup only comes with a handover
  a_wake_handed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |-> (out_status == rmpi_pkg::ST_HANDED))
    else $error("wakeup without handover status");

  // A bad unlock has no side effects
  a_bad_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rmpi_pkg::ST_BAD_UNLOCK)) |->
      (!out_success && !out_wake_valid && !out_prio_update_valid))
    else $error("bad unlock reported side effects");

  // Unused update fields read as zero
  a_pu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_prio_update_valid) |->
      ((out_prio_update_task == '0) && (out_prio_update_value == '0)))
    else $error("priority update fields not cleared");

endmodule

bind recursive_mutex_priority_inherit_top rmpi_checker #(
  .PRIO_BITS (PRIO_BITS)
) u_rmpi_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_status            (out_status),
  .out_success           (out_success),
  .out_wake_valid        (out_wake_valid),
  .out_wake_task         (out_wake_task),
  .out_prio_update_valid (out_prio_update_valid),
  .out_prio_update_task  (out_prio_update_task),
  .out_prio_update_value (out_prio_update_value)
);

`default_nettype wire
